FILE: sv/weather_frame_decoder_unit_macros.svh
// Assertion macros shared by the weather frame decoder front parser and queue.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef WEATHER_FRAME_DECODER_UNIT_MACROS_SVH
`define WEATHER_FRAME_DECODER_UNIT_MACROS_SVH
`ifndef SYNTH
`define WFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WFD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WFD_ASSERT(lbl, prop, msg)
`define WFD_NEVER(lbl, cond, msg)
`endif
`endif

FILE: sv/wfd_pkg.sv
package wfd_pkg;

  localparam logic [7:0] START_BYTE = 8'h63;
  localparam int         FRAME_LEN  = 35;
  localparam int         POS_W      = 6;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  localparam int SPD_W  = 10;
  localparam int HUM_W  = 7;
  localparam int PRES_W = 17;
  localparam int WIND_W = 26;
  localparam int TEMP_W = 17;
  localparam int RAIN_W = 18;

  // Unit conversion constants.
  localparam logic [18:0] UM_S_PER_MPH      = 19'd447040;
  localparam logic [7:0]  UM_PER_CENTI_INCH = 8'd254;
  localparam logic [WIND_W-1:0] WIND_MAX    = {WIND_W{1'b1}};
  localparam logic [SPD_W-1:0]  F_OFFSET    = 10'd32;
  localparam logic [8:0]  CENTI_X5          = 9'd500;
  localparam logic [2:0]  ROUND_BIAS        = 3'd4;
  // floor(x / 9) == (x * RECIP_NINE) >> RECIP_SHIFT for every x below 2**21.
  localparam logic [20:0] RECIP_NINE        = 21'd1864136;
  localparam int          RECIP_SHIFT       = 24;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int OUT_TDATA_W = 144;

  // Raw accumulator contents of one finished frame.
  typedef struct packed {
    logic [SPD_W-1:0]  dir;
    logic [SPD_W-1:0]  avg;
    logic [SPD_W-1:0]  peak;
    logic [SPD_W-1:0]  fahr;
    logic [SPD_W-1:0]  rain_h;
    logic [SPD_W-1:0]  rain_d;
    logic [HUM_W-1:0]  hum;
    logic [PRES_W-1:0] pres;
    logic              err;
  } wfd_raw_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wfd_q_stat_t;

endpackage

FILE: sv/weather_frame_decoder_unit.sv
// After the transfer of the 35th frame byte, the record passes the queue, stage A, stage B and the output register.
// Throughput: one byte per cycle on the input; the output side can take a record per cycle.
// The input stalls only on a frame's last byte while the two-entry record queue is full.
// Reset: rst_ni is asynchronous and active low; it empties the queue and the pipeline
// and returns the parser to waiting for the start byte.
module weather_frame_decoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [9:0] wind_direction_deg, [35:10] wind_avg_um_s, [61:36] wind_peak_um_s,
  // [78:62] temperature_centi_c, [96:79] rain_hour_um, [114:97] rain_day_um,
  // [121:115] humidity_pct, [138:122] pressure_tenth_hpa, [139] format_error,
  // [143:140] zero
  output logic [143:0] m_axis_tdata_o
);
  import wfd_pkg::*;

  // The front parser walks the frame one byte per transfer. It drops bytes until
  // it sees the start byte, then accumulates the decimal digit ranges of the frame
  // into per-field registers and flags any non-digit byte found in a numeric range.
  // On the last frame byte it pushes the raw accumulators into a short queue.
  wfd_raw_t    rec;
  wfd_raw_t    q_data;
  wfd_q_stat_t q_stat;
  logic        push, pop;

  wfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid_i),
    .rx_ready_o (s_axis_tready_o),
    .rx_byte_i  (s_axis_tdata_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .rec_o      (rec)
  );

  // The queue decouples parsing from unit conversion, so a stalled output
  // does not hold up the incoming byte stream until the queue fills.
  wfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rec),
    .pop_i  (pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  // The back end converts units in a three-stage pipeline: constant multiplies,
  // then wind saturation and a reciprocal multiply that divides the temperature
  // by nine, then the sign of the temperature and the output register.
  wfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: sv/wfd_front.sv
`include "weather_frame_decoder_unit_macros.svh"

module wfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  wfd_pkg::wfd_q_stat_t q_stat_i,
  output logic                push_o,
  output wfd_pkg::wfd_raw_t   rec_o
);
  import wfd_pkg::*;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef enum logic [3:0] {
    FLD_NONE, FLD_DIR, FLD_AVG, FLD_PEAK, FLD_TEMP,
    FLD_RAINH, FLD_RAIND, FLD_HUM, FLD_PRES
  } fld_e;

  function automatic logic [PRES_W-1:0] push_digit(logic [PRES_W-1:0] acc, logic [3:0] d);
    logic [PRES_W+3:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + (PRES_W+4)'(d);
    return t[PRES_W-1:0];
  endfunction

  logic [POS_W-1:0] pos_q;
  wfd_raw_t         rec_q, rec_d;
  fld_e             fld;
  logic             accept, is_digit;
  logic [3:0]       digit;

  assign accept   = rx_valid_i && rx_ready_o;
  assign is_digit = (rx_byte_i >= ASCII_ZERO) && (rx_byte_i <= ASCII_NINE);
  assign digit    = is_digit ? 4'(rx_byte_i - ASCII_ZERO) : 4'd0;

  // Only the last byte of a frame hands a record to the queue.
  assign rx_ready_o = !((pos_q == LAST_POS) && q_stat_i.full);
  assign push_o     = accept && (pos_q == LAST_POS);
  assign rec_o      = rec_q;

  always_comb begin
    unique case (pos_q) inside
      [6'd1:6'd3]:   fld = FLD_DIR;
      [6'd5:6'd7]:   fld = FLD_AVG;
      [6'd9:6'd11]:  fld = FLD_PEAK;
      [6'd13:6'd15]: fld = FLD_TEMP;
      [6'd17:6'd19]: fld = FLD_RAINH;
      [6'd21:6'd23]: fld = FLD_RAIND;
      [6'd25:6'd26]: fld = FLD_HUM;
      [6'd28:6'd32]: fld = FLD_PRES;
      default:       fld = FLD_NONE;
    endcase
  end

  always_comb begin
    rec_d = rec_q;
    unique case (fld)
      FLD_DIR:   rec_d.dir    = SPD_W'(push_digit(PRES_W'(rec_q.dir), digit));
      FLD_AVG:   rec_d.avg    = SPD_W'(push_digit(PRES_W'(rec_q.avg), digit));
      FLD_PEAK:  rec_d.peak   = SPD_W'(push_digit(PRES_W'(rec_q.peak), digit));
      FLD_TEMP:  rec_d.fahr   = SPD_W'(push_digit(PRES_W'(rec_q.fahr), digit));
      FLD_RAINH: rec_d.rain_h = SPD_W'(push_digit(PRES_W'(rec_q.rain_h), digit));
      FLD_RAIND: rec_d.rain_d = SPD_W'(push_digit(PRES_W'(rec_q.rain_d), digit));
      FLD_HUM:   rec_d.hum    = HUM_W'(push_digit(PRES_W'(rec_q.hum), digit));
      FLD_PRES:  rec_d.pres   = push_digit(rec_q.pres, digit);
      default: begin
      end
    endcase
    if ((fld != FLD_NONE) && !is_digit) begin
      rec_d.err = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rec_q <= '0;
    end else if (accept) begin
      if (pos_q == '0) begin
        if (rx_byte_i == START_BYTE) begin
          rec_q <= '0;
          pos_q <= POS_W'(1);
        end
      end else begin
        rec_q <= rec_d;
        pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
      end
    end
  end

  `WFD_NEVER(a_pos_range, pos_q > LAST_POS, "frame position beyond last byte")

endmodule

FILE: sv/wfd_queue.sv
`include "weather_frame_decoder_unit_macros.svh"

module wfd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wfd_pkg::wfd_raw_t    data_i,
  input  logic                 pop_i,
  output wfd_pkg::wfd_raw_t    data_o,
  output wfd_pkg::wfd_q_stat_t stat_o
);
  import wfd_pkg::*;

  wfd_raw_t           ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  `WFD_NEVER(a_no_overflow, push_i && stat_o.full, "record pushed into a full queue")
  `WFD_NEVER(a_no_underflow, pop_i && stat_o.empty, "record popped from an empty queue")

endmodule

FILE: sv/wfd_back.sv
module wfd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wfd_pkg::wfd_q_stat_t     q_stat_i,
  input  wfd_pkg::wfd_raw_t        q_data_i,
  output logic                     pop_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [wfd_pkg::OUT_TDATA_W-1:0] m_data_o
);
  import wfd_pkg::*;

  localparam int WPROD_W = 29;
  localparam int TX_W    = 19;
  localparam int TP_W    = 40;
  localparam int Q_W     = TP_W - RECIP_SHIFT;

  typedef struct packed {
    logic [SPD_W-1:0]   dir;
    logic [WPROD_W-1:0] avg_p;
    logic [WPROD_W-1:0] peak_p;
    logic               neg;
    logic [TX_W-1:0]    tx;
    logic [RAIN_W-1:0]  rain_h;
    logic [RAIN_W-1:0]  rain_d;
    logic [HUM_W-1:0]   hum;
    logic [PRES_W-1:0]  pres;
    logic               err;
  } stg_a_t;

  typedef struct packed {
    logic [SPD_W-1:0]  dir;
    logic [WIND_W-1:0] avg;
    logic [WIND_W-1:0] peak;
    logic              neg;
    logic [TP_W-1:0]   tp;
    logic [RAIN_W-1:0] rain_h;
    logic [RAIN_W-1:0] rain_d;
    logic [HUM_W-1:0]  hum;
    logic [PRES_W-1:0] pres;
    logic              err;
  } stg_b_t;

  stg_a_t a_q, a_d;
  stg_b_t b_q, b_d;
  logic [OUT_TDATA_W-1:0] o_q, o_d;
  logic a_vld_q, b_vld_q, o_vld_q, en;
  logic [SPD_W-1:0] mag;
  logic [Q_W-1:0]   quot;
  logic [TEMP_W-1:0] temp;

  // The whole pipeline advances while the output register is free or drained.
  assign en        = !o_vld_q || m_ready_i;
  assign pop_o     = en && !q_stat_i.empty;
  assign m_valid_o = o_vld_q;
  assign m_data_o  = o_q;

  // Stage A: constant multiplies and the Fahrenheit offset.
  always_comb begin
    mag = (q_data_i.fahr >= F_OFFSET) ? q_data_i.fahr - F_OFFSET : F_OFFSET - q_data_i.fahr;
    a_d.dir    = q_data_i.dir;
    a_d.avg_p  = WPROD_W'(q_data_i.avg) * WPROD_W'(UM_S_PER_MPH);
    a_d.peak_p = WPROD_W'(q_data_i.peak) * WPROD_W'(UM_S_PER_MPH);
    a_d.neg    = (q_data_i.fahr < F_OFFSET);
    a_d.tx     = TX_W'(mag) * TX_W'(CENTI_X5) + TX_W'(ROUND_BIAS);
    a_d.rain_h = RAIN_W'(q_data_i.rain_h) * RAIN_W'(UM_PER_CENTI_INCH);
    a_d.rain_d = RAIN_W'(q_data_i.rain_d) * RAIN_W'(UM_PER_CENTI_INCH);
    a_d.hum    = q_data_i.hum;
    a_d.pres   = q_data_i.pres;
    a_d.err    = q_data_i.err;
  end

  // Stage B: wind saturation and the reciprocal multiply for the divide by nine.
  always_comb begin
    b_d.dir    = a_q.dir;
    b_d.avg    = (a_q.avg_p > WPROD_W'(WIND_MAX)) ? WIND_MAX : a_q.avg_p[WIND_W-1:0];
    b_d.peak   = (a_q.peak_p > WPROD_W'(WIND_MAX)) ? WIND_MAX : a_q.peak_p[WIND_W-1:0];
    b_d.neg    = a_q.neg;
    b_d.tp     = TP_W'(a_q.tx) * TP_W'(RECIP_NINE);
    b_d.rain_h = a_q.rain_h;
    b_d.rain_d = a_q.rain_d;
    b_d.hum    = a_q.hum;
    b_d.pres   = a_q.pres;
    b_d.err    = a_q.err;
  end

  // Output stage: take the quotient, apply the sign and pack the record.
  always_comb begin
    quot = b_q.tp[TP_W-1:RECIP_SHIFT];
    temp = b_q.neg ? TEMP_W'(0) - TEMP_W'(quot) : TEMP_W'(quot);
    o_d  = {4'b0000, b_q.err, b_q.pres, b_q.hum, b_q.rain_d, b_q.rain_h,
            temp, b_q.peak, b_q.avg, b_q.dir};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      o_q <= o_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= !q_stat_i.empty;
      b_vld_q <= a_vld_q;
      o_vld_q <= b_vld_q;
    end
  end

endmodule

FILE: tb/sv/weather_frame_decoder_unit_tb.sv
module weather_frame_decoder_unit_tb;

  localparam int FRAME_BYTES    = wfd_pkg::FRAME_LEN;
  localparam int HOLD_CYCLES    = 800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_LIMIT   = 10;

  // One decoded station record, in the units that the output stream carries.
  typedef struct {
    logic [9:0]         dir_deg;
    logic [25:0]        avg_um_s;
    logic [25:0]        peak_um_s;
    logic signed [16:0] temp_cc;
    logic [17:0]        rain_h_um;
    logic [17:0]        rain_d_um;
    logic [6:0]         hum_pct;
    logic [16:0]        pres_tenth_hpa;
    logic               fmt_err;
  } weather_rec_t;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i  = 8'h00;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;

  // Bytes waiting to be sent, and records the parser is known to owe us.
  logic [7:0]   byte_q [$];
  weather_rec_t expected_q [$];
  logic [7:0]   frame_buf [FRAME_BYTES];

  // Shadow copy of the parser state.
  int unsigned frame_pos;
  int unsigned dir_acc, avg_acc, peak_acc, fahr_acc;
  int unsigned rain_h_acc, rain_d_acc, hum_acc, pres_acc;
  bit          bad_char;

  bit byte_taken   = 1'b0;
  bit rec_taken    = 1'b0;
  bit hold_off     = 1'b0;
  bit send_calm    = 1'b0;
  bit recv_calm    = 1'b0;
  int send_wait    = 0;
  int recv_wait    = 0;
  int records_seen = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  weather_frame_decoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned next_decimal(input int unsigned acc, input int unsigned digit,
                                               input int unsigned mask);
    return (acc * 10 + digit) & mask;
  endfunction

  // Miles per hour to micrometres per second; anything past 26 bits clips to all ones.
  function automatic logic [25:0] mph_to_um_s(input int unsigned mph);
    longint unsigned um_s;
    um_s = longint'(mph) * 447040;
    return (um_s > 64'h3FF_FFFF) ? 26'h3FF_FFFF : um_s[25:0];
  endfunction

  // (F - 32) * 5/9 in hundredths, rounded to nearest; ties cannot occur for integer F.
  function automatic logic signed [16:0] fahr_to_centi_c(input int unsigned fahr);
    int centi;
    if (fahr >= 32) begin
      centi = int'(((fahr - 32) * 500 + 4) / 9);
    end else begin
      centi = -int'(((32 - fahr) * 500 + 4) / 9);
    end
    return 17'(centi);
  endfunction

  function automatic bit is_numeric_pos(input int unsigned p);
    return !(p == 0 || p == 4 || p == 8 || p == 12 || p == 16 || p == 20 || p == 24 ||
             p == 27 || p >= 33);
  endfunction

  function automatic int unsigned pick_value(input int unsigned top);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // Advance the shadow parser by one byte and queue a record when a frame closes.
  task automatic parse_byte(input logic [7:0] b);
    bit           is_digit;
    bit           numeric;
    int unsigned  d;
    weather_rec_t rec;
    is_digit = (b >= 8'h30) && (b <= 8'h39);
    d        = is_digit ? int'(b) - 'h30 : 0;
    if (frame_pos == 0) begin
      if (b == wfd_pkg::START_BYTE) begin
        dir_acc    = 0;
        avg_acc    = 0;
        peak_acc   = 0;
        fahr_acc   = 0;
        rain_h_acc = 0;
        rain_d_acc = 0;
        hum_acc    = 0;
        pres_acc   = 0;
        bad_char   = 1'b0;
        frame_pos  = 1;
      end
    end else begin
      numeric = 1'b1;
      if (frame_pos <= 3) begin
        dir_acc = next_decimal(dir_acc, d, 'h3FF);
      end else if (frame_pos >= 5 && frame_pos <= 7) begin
        avg_acc = next_decimal(avg_acc, d, 'h3FF);
      end else if (frame_pos >= 9 && frame_pos <= 11) begin
        peak_acc = next_decimal(peak_acc, d, 'h3FF);
      end else if (frame_pos >= 13 && frame_pos <= 15) begin
        fahr_acc = next_decimal(fahr_acc, d, 'h3FF);
      end else if (frame_pos >= 17 && frame_pos <= 19) begin
        rain_h_acc = next_decimal(rain_h_acc, d, 'h3FF);
      end else if (frame_pos >= 21 && frame_pos <= 23) begin
        rain_d_acc = next_decimal(rain_d_acc, d, 'h3FF);
      end else if (frame_pos >= 25 && frame_pos <= 26) begin
        hum_acc = next_decimal(hum_acc, d, 'h7F);
      end else if (frame_pos >= 28 && frame_pos <= 32) begin
        pres_acc = next_decimal(pres_acc, d, 'h1FFFF);
      end else begin
        numeric = 1'b0;
      end
      if (numeric && !is_digit) bad_char = 1'b1;

      if (frame_pos == FRAME_BYTES - 1) begin
        rec.dir_deg        = dir_acc[9:0];
        rec.avg_um_s       = mph_to_um_s(avg_acc);
        rec.peak_um_s      = mph_to_um_s(peak_acc);
        rec.temp_cc        = fahr_to_centi_c(fahr_acc);
        rec.rain_h_um      = 18'(rain_h_acc * 254);
        rec.rain_d_um      = 18'(rain_d_acc * 254);
        rec.hum_pct        = hum_acc[6:0];
        rec.pres_tenth_hpa = pres_acc[16:0];
        rec.fmt_err        = bad_char;
        expected_q.push_back(rec);
        frame_pos = 0;
      end else begin
        frame_pos++;
      end
    end
  endtask

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  function automatic void compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      log_failure($sformatf("record %0d %s: expected %0d, got %0d",
                            records_seen, name, want, got));
    end
  endfunction

  task automatic check_record(input logic [143:0] raw);
    weather_rec_t want;
    records_seen++;
    if (expected_q.size() == 0) begin
      log_failure($sformatf("record %0d arrived with nothing expected: %h", records_seen, raw));
    end else begin
      want = expected_q.pop_front();
      if ($isunknown(raw)) begin
        log_failure($sformatf("record %0d has unknown bits: %h", records_seen, raw));
      end else begin
        compare_field("wind_direction_deg",  want.dir_deg,        raw[9:0]);
        compare_field("wind_avg_um_s",       want.avg_um_s,       raw[35:10]);
        compare_field("wind_peak_um_s",      want.peak_um_s,      raw[61:36]);
        compare_field("temperature_centi_c", want.temp_cc,        $signed(raw[78:62]));
        compare_field("rain_hour_um",        want.rain_h_um,      raw[96:79]);
        compare_field("rain_day_um",         want.rain_d_um,      raw[114:97]);
        compare_field("humidity_pct",        want.hum_pct,        raw[121:115]);
        compare_field("pressure_tenth_hpa",  want.pres_tenth_hpa, raw[138:122]);
        compare_field("format_error",        want.fmt_err,        raw[139]);
        compare_field("padding",             0,                   raw[143:140]);
      end
    end
  endtask

  task automatic put_digits(input int start, input int len, input int unsigned value);
    int unsigned v;
    v = value;
    for (int k = len - 1; k >= 0; k--) begin
      frame_buf[start + k] = 8'h30 + 8'(v % 10);
      v = v / 10;
    end
  endtask

  // Lay out a well-formed frame; separators get arbitrary bytes.
  task automatic build_frame(input int unsigned dir, input int unsigned avg,
                             input int unsigned peak, input int unsigned fahr,
                             input int unsigned rain_h, input int unsigned rain_d,
                             input int unsigned hum, input int unsigned pres);
    for (int p = 0; p < FRAME_BYTES; p++) frame_buf[p] = 8'($urandom_range(0, 255));
    frame_buf[0] = wfd_pkg::START_BYTE;
    put_digits(1, 3, dir);
    put_digits(5, 3, avg);
    put_digits(9, 3, peak);
    put_digits(13, 3, fahr);
    put_digits(17, 3, rain_h);
    put_digits(21, 3, rain_d);
    put_digits(25, 2, hum);
    put_digits(28, 5, pres);
  endtask

  task automatic push_frame(input int count);
    for (int p = 0; p < count; p++) byte_q.push_back(frame_buf[p]);
  endtask

  // Sender: holds a byte until it is taken, then waits a drawn number of cycles.
  always @(negedge clk_i) begin : feed_bytes
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = s_axis_tvalid_i;
    next_byte  = s_axis_tdata_i;
    if (rst_ni && (!s_axis_tvalid_i || byte_taken)) begin
      next_valid = 1'b0;
      if (byte_taken) begin
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 3);
      end
      if (send_wait > 0) begin
        send_wait--;
      end else if (byte_q.size() != 0) begin
        next_valid = 1'b1;
        next_byte  = byte_q.pop_front();
      end
    end
    s_axis_tvalid_i <= next_valid;
    s_axis_tdata_i  <= next_byte;
  end

  // Receiver: after each record it stalls for a drawn number of cycles.
  always @(negedge clk_i) begin : take_records
    if (rec_taken) begin
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
    end
    if (!rst_ni || hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch_streams
    byte_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    rec_taken  = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (byte_taken) parse_byte(s_axis_tdata_i);
    if (rec_taken) check_record(m_axis_tdata_o);
    if (byte_taken || rec_taken || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL weather_frame_decoder_unit");
      $finish;
    end
  end

  // Once traffic is flowing, block the output long enough for the record queue to fill
  // and push back on the byte stream.
  initial begin : long_stall
    while (records_seen < 12) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    int unsigned n_noise;
    int unsigned p;
    int          keep;
    logic [7:0]  junk;

    frame_pos = 0;
    bad_char  = 1'b0;

    // Smallest readings everywhere: 0 F gives the most negative temperature.
    build_frame(0, 0, 0, 0, 0, 0, 0, 0);
    push_frame(FRAME_BYTES);
    // Largest readings: both wind fields clip, rain and pressure at full scale.
    build_frame(999, 999, 999, 999, 999, 999, 99, 99999);
    push_frame(FRAME_BYTES);
    // Wind just below and just above the clipping point, freezing point exactly.
    build_frame(1, 150, 151, 32, 1, 1, 1, 1);
    push_frame(FRAME_BYTES);
    // One degree either side of freezing.
    build_frame(360, 1, 0, 31, 500, 250, 50, 10132);
    push_frame(FRAME_BYTES);
    build_frame(180, 12, 34, 33, 7, 8, 45, 9876);
    push_frame(FRAME_BYTES);
    // Non-digits in numeric positions, including the neighbors of '0' and '9' and a 'c'.
    build_frame(123, 45, 67, 89, 10, 11, 12, 34567);
    frame_buf[1]  = 8'h2F;
    frame_buf[6]  = 8'h3A;
    frame_buf[13] = wfd_pkg::START_BYTE;
    frame_buf[19] = 8'h80;
    frame_buf[25] = 8'h00;
    frame_buf[32] = 8'hFF;
    push_frame(FRAME_BYTES);
    // Line noise before a start byte is dropped; 'c' in every separator is just data.
    byte_q.push_back(8'h62);
    byte_q.push_back(8'h64);
    byte_q.push_back(8'h43);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    build_frame(270, 20, 30, 72, 3, 4, 80, 10050);
    for (int s = 1; s < FRAME_BYTES; s++) begin
      if (!is_numeric_pos(s)) frame_buf[s] = wfd_pkg::START_BYTE;
    end
    push_frame(FRAME_BYTES);
    // A cut-off frame: the next frame's start byte lands inside it and does not restart.
    build_frame(100, 5, 6, 100, 9, 9, 9, 9);
    push_frame(12);
    build_frame(200, 7, 8, 50, 1, 2, 3, 4);
    push_frame(FRAME_BYTES);
    build_frame(90, 3, 4, 60, 2, 2, 20, 10000);
    push_frame(FRAME_BYTES);

    // Random traffic: mostly well-formed frames, some noise, spoiled and cut-off frames.
    for (int fr = 0; fr < 37; fr++) begin
      if ($urandom_range(0, 2) == 0) begin
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) begin
          junk = 8'($urandom_range(0, 255));
          if (junk == wfd_pkg::START_BYTE) junk = 8'h00;
          byte_q.push_back(junk);
        end
      end
      build_frame(pick_value(999),
                  $urandom_range(0, 1) ? pick_value(999) : $urandom_range(140, 160),
                  $urandom_range(0, 1) ? pick_value(999) : $urandom_range(140, 160),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : pick_value(999),
                  pick_value(999), pick_value(999), pick_value(99), pick_value(99999));
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do p = $urandom_range(1, 32); while (!is_numeric_pos(p));
          do junk = 8'($urandom_range(0, 255)); while (junk >= 8'h30 && junk <= 8'h39);
          frame_buf[p] = junk;
        end
      end
      keep = ($urandom_range(0, 11) == 0) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
      push_frame(keep);
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS weather_frame_decoder_unit");
    end else begin
      $display("FAIL weather_frame_decoder_unit");
    end
    $finish;
  end

endmodule
